/* sv/ksd_pkg.sv */
// ksd_pkg: constants and key tables for the scan code set 1 decoder
// used by keyboard_scan_decoder_led_sender; no dependencies
package ksd_pkg;

  localparam int unsigned QueueDepth = 32;
  localparam int unsigned QAW = $clog2(QueueDepth);
  localparam int unsigned QCW = $clog2(QueueDepth + 1);

  localparam logic [7:0] CMD_LED     = 8'hED;
  localparam logic [7:0] ACK_BYTE    = 8'hFA;
  localparam logic [7:0] RESEND_BYTE = 8'hFE;
  localparam logic [7:0] SC_LSHIFT   = 8'h2A;
  localparam logic [7:0] SC_RSHIFT   = 8'h36;
  localparam logic [7:0] SC_LSHIFT_B = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_B = 8'hB6;
  localparam logic [7:0] SC_CAPS     = 8'h3A;
  localparam logic [7:0] SC_NUM      = 8'h45;
  localparam logic [7:0] SC_SCROLL   = 8'h46;
  localparam logic [7:0] SC_BKSP     = 8'h0E;
  localparam logic [7:0] SC_TAB      = 8'h0F;
  localparam logic [7:0] SC_ENTER    = 8'h1C;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_BKSP  = 2'd1;
  localparam logic [1:0] EV_TAB   = 2'd2;
  localparam logic [1:0] EV_ENTER = 2'd3;

  localparam logic [0:0] REQ_KEY   = 1'b0;
  localparam logic [0:0] REQ_START = 1'b1;

  localparam logic [6:0] PLAIN_TAB [128] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h5e, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4f, 7'h50, 7'h40, 7'h5b, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h3b,
    7'h3a, 7'h00, 7'h00, 7'h5d, 7'h5a, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4e, 7'h4d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h5c, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h5c, 7'h00, 7'h00
  };

  localparam logic [6:0] SHIFT_TAB [128] = '{
    7'h00, 7'h00, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
    7'h27, 7'h28, 7'h29, 7'h7e, 7'h3d, 7'h7e, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4f, 7'h50, 7'h60, 7'h7b, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4a, 7'h4b, 7'h4c, 7'h2b,
    7'h2a, 7'h00, 7'h00, 7'h7d, 7'h5a, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4e, 7'h4d, 7'h3c, 7'h3e, 7'h3f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2e, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h5f, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h7c, 7'h00, 7'h00
  };

endpackage

/* sv/keyboard_scan_decoder_led_sender.sv */
// keyboard_scan_decoder_led_sender: scan code set 1 decoder with LED command queue
// depends on ksd_pkg
//
// usage:
//   s_axis carries one word per keyboard byte: tdata = scan byte,
//   tuser = request kind (0 keyboard byte, 1 start). a start word loads
//   the LEDs from cfg_wdata_i (written with cfg_we_i while idle), clears
//   shift and queues the LED command pair
//   m_axis returns exactly one word per input word: decoded character,
//   key event, the byte sent to the keyboard this word, LED and shift state
//   and a drop flag when the command queue had no room for the whole pair
//   the output is registered: a word accepted at one edge shows on m_axis
//   after that edge. throughput is one word per cycle while m_axis does not
//   stall, set by the single output register; the state update and queue
//   access finish in the same cycle
//   when m_axis stalls the output register holds, and s_axis_tready drops
//   only while the held word is not taken
//   reset clears shift, LEDs, queue pointers and the pending acknowledge;
//   queue contents are not cleared and no clearing pass is needed
module keyboard_scan_decoder_led_sender (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // scan_byte
  input  logic [0:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // char_valid, char_code[7], key_event[2],
                                     // send_valid, send_byte[8], led_state[3],
                                     // shift_state[2], cmd_dropped, zero pad
);

  localparam int unsigned D   = ksd_pkg::QueueDepth;
  localparam int unsigned AW  = ksd_pkg::QAW;
  localparam int unsigned CW  = ksd_pkg::QCW;

  logic [2:0]    init_q;
  logic [1:0]    shift_q, shift_d;
  logic [2:0]    led_q, led_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ack_q, ack_d;
  logic [7:0]    pend_q, pend_d;
  logic [7:0]    mem_q [D];
  logic          out_v_q;
  logic [31:0]   out_q, out_d;

  logic          acc;
  logic [7:0]    b;
  logic          is_start;
  logic [6:0]    ch;
  logic [1:0]    ev;
  logic          push, ok1, ok2, dropped, sv, pop;
  logic [7:0]    sb;
  logic [AW:0]   tail_w, tail2_w;
  logic [AW-1:0] tail1, tail2;
  logic [CW-1:0] cnt_p;

  assign s_axis_tready = !out_v_q || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign b = s_axis_tdata;
  assign is_start = (s_axis_tuser == ksd_pkg::REQ_START);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata = out_q;

  always_comb begin
    shift_d = shift_q;
    led_d   = led_q;
    ack_d   = ack_q;
    ch      = '0;
    ev      = ksd_pkg::EV_NONE;
    push    = 1'b0;
    sv      = 1'b0;
    sb      = '0;
    if (is_start) begin
      led_d   = init_q;
      shift_d = '0;
      push    = 1'b1;
    end else begin
      if (!b[7]) begin
        ch = (shift_q == 2'd0) ? ksd_pkg::PLAIN_TAB[b[6:0]] : ksd_pkg::SHIFT_TAB[b[6:0]];
        if (ch >= 7'h41 && ch <= 7'h5A && (led_q[2] == (shift_q != 2'd0))) begin
          ch = ch + 7'h20;
        end
      end
      case (b)
        ksd_pkg::SC_BKSP:  ev = ksd_pkg::EV_BKSP;
        ksd_pkg::SC_TAB:   ev = ksd_pkg::EV_TAB;
        ksd_pkg::SC_ENTER: ev = ksd_pkg::EV_ENTER;
        default:           ev = ksd_pkg::EV_NONE;
      endcase
      case (b)
        ksd_pkg::SC_LSHIFT:   shift_d[0] = 1'b1;
        ksd_pkg::SC_RSHIFT:   shift_d[1] = 1'b1;
        ksd_pkg::SC_LSHIFT_B: shift_d[0] = 1'b0;
        ksd_pkg::SC_RSHIFT_B: shift_d[1] = 1'b0;
        ksd_pkg::SC_CAPS: begin
          led_d[2] = !led_q[2];
          push = 1'b1;
        end
        ksd_pkg::SC_NUM: begin
          led_d[1] = !led_q[1];
          push = 1'b1;
        end
        ksd_pkg::SC_SCROLL: begin
          led_d[0] = !led_q[0];
          push = 1'b1;
        end
        ksd_pkg::ACK_BYTE: ack_d = 1'b0;
        ksd_pkg::RESEND_BYTE: begin
          if (ack_q) begin
            sv = 1'b1;
            sb = pend_q;
          end
        end
        default: ;
      endcase
    end

    ok1 = push && (cnt_q < CW'(D));
    ok2 = push && (cnt_q < CW'(D - 1));
    dropped = push && !ok2;
    cnt_p = cnt_q + CW'(ok1) + CW'(ok2);

    tail_w  = (AW+1)'(head_q) + (AW+1)'(cnt_q);
    if (tail_w >= (AW+1)'(D)) tail_w = tail_w - (AW+1)'(D);
    tail1   = tail_w[AW-1:0];
    tail2_w = tail_w + (AW+1)'(1);
    if (tail2_w >= (AW+1)'(D)) tail2_w = tail2_w - (AW+1)'(D);
    tail2   = tail2_w[AW-1:0];

    pop    = !sv && !ack_d && (cnt_p != '0);
    head_d = head_q;
    cnt_d  = cnt_p;
    pend_d = pend_q;
    if (pop) begin
      pend_d = (cnt_q == '0) ? ksd_pkg::CMD_LED : mem_q[head_q];
      head_d = (head_q == AW'(D - 1)) ? '0 : head_q + AW'(1);
      cnt_d  = cnt_p - CW'(1);
      ack_d  = 1'b1;
      sv     = 1'b1;
      sb     = pend_d;
    end

    out_d = {7'd0, dropped, shift_d, led_d, sb, sv, ev, ch, (ch != 7'd0)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q  <= '0;
      shift_q <= '0;
      led_q   <= '0;
      head_q  <= '0;
      cnt_q   <= '0;
      ack_q   <= 1'b0;
      pend_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) init_q <= cfg_wdata_i;
      if (acc) begin
        shift_q <= shift_d;
        led_q   <= led_d;
        head_q  <= head_d;
        cnt_q   <= cnt_d;
        ack_q   <= ack_d;
        pend_q  <= pend_d;
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) out_q <= out_d;
    if (acc && ok1) mem_q[tail1] <= ksd_pkg::CMD_LED;
    if (acc && ok2) mem_q[tail2] <= {5'd0, led_d};
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(D)) else $error("queue count beyond depth");

  a_send_sets_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && sv |=> ack_q) else $error("byte sent without pending acknowledge");

  a_start_leds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && is_start |=> (led_q == $past(init_q)) && (shift_q == 2'd0))
    else $error("start did not load leds");

  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && dropped |=> (cnt_q >= CW'(D - 1))) else $error("drop with room in queue");

endmodule
